FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ac3sh_pkg.sv
// ----------------------------------------------------------------------------
// ac3sh_pkg
// Types, codes and header lookup tables for the AC-3 sync/header parser.
// ----------------------------------------------------------------------------
package ac3sh_pkg;

  localparam logic [15:0] SYNC_WORD      = 16'h0B77;
  localparam logic [4:0]  BSID_EXPECTED  = 5'h08;
  localparam logic [5:0]  FRMSIZE_CODES  = 6'd38;
  localparam logic [1:0]  FSCOD_RESERVED = 2'd3;
  localparam logic [16:0] SEARCH_TAIL    = 17'd8;   // sync must start by length-8
  localparam logic [15:0] HEADER_LEAD    = 16'd5;   // sync, crc, code bytes before bsid
  localparam logic [15:0] POS_MAX        = 16'hFFFF;

  localparam logic [1:0] HDR_CODE = 2'd2;  // header byte holding fscod/frmsizecod
  localparam logic [1:0] HDR_BSID = 2'd3;  // header byte holding bsid/bsmod

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SYNC  = 2'd1,
    ST_BAD_RATE = 2'd2,
    ST_BAD_BSID = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_HEADER,
    PH_DRAIN
  } phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] buffer_length;
    logic        last_byte;
  } byte_req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] skipped_bytes;
    logic [15:0] sample_rate_hz;
    logic [11:0] frame_bytes;
    logic [9:0]  bitrate_kbps;
    logic [2:0]  stream_mode;
  } result_t;

  function automatic logic [15:0] sample_rate(input logic [1:0] fscod);
    logic [15:0] hz;
    case (fscod)
      2'd0:    hz = 16'd48000;
      2'd1:    hz = 16'd44100;
      2'd2:    hz = 16'd32000;
      default: hz = 16'd0;
    endcase
    return hz;
  endfunction

  // Nominal bitrate; codes come in pairs, 38 and up give zero.
  function automatic logic [9:0] bitrate(input logic [5:0] frmsizecod);
    logic [9:0] kbps;
    case (frmsizecod[5:1])
      5'd0:    kbps = 10'd32;
      5'd1:    kbps = 10'd40;
      5'd2:    kbps = 10'd48;
      5'd3:    kbps = 10'd56;
      5'd4:    kbps = 10'd64;
      5'd5:    kbps = 10'd80;
      5'd6:    kbps = 10'd96;
      5'd7:    kbps = 10'd112;
      5'd8:    kbps = 10'd128;
      5'd9:    kbps = 10'd160;
      5'd10:   kbps = 10'd192;
      5'd11:   kbps = 10'd224;
      5'd12:   kbps = 10'd256;
      5'd13:   kbps = 10'd320;
      5'd14:   kbps = 10'd384;
      5'd15:   kbps = 10'd448;
      5'd16:   kbps = 10'd512;
      5'd17:   kbps = 10'd576;
      5'd18:   kbps = 10'd640;
      default: kbps = 10'd0;
    endcase
    return kbps;
  endfunction

  // 44.1 kHz word count for the even code of each pair; odd codes add one.
  function automatic logic [10:0] words_44k(input logic [5:0] frmsizecod);
    logic [10:0] w;
    case (frmsizecod[5:1])
      5'd0:    w = 11'd69;
      5'd1:    w = 11'd87;
      5'd2:    w = 11'd104;
      5'd3:    w = 11'd121;
      5'd4:    w = 11'd139;
      5'd5:    w = 11'd174;
      5'd6:    w = 11'd208;
      5'd7:    w = 11'd243;
      5'd8:    w = 11'd278;
      5'd9:    w = 11'd348;
      5'd10:   w = 11'd417;
      5'd11:   w = 11'd487;
      5'd12:   w = 11'd557;
      5'd13:   w = 11'd696;
      5'd14:   w = 11'd835;
      5'd15:   w = 11'd975;
      5'd16:   w = 11'd1114;
      5'd17:   w = 11'd1253;
      5'd18:   w = 11'd1393;
      default: w = 11'd0;
    endcase
    return w + {10'd0, frmsizecod[0]};
  endfunction

  // Frame size in 16-bit words: 48k is 2x kbps, 32k is 3x kbps.
  function automatic logic [10:0] frame_words(input logic [5:0] frmsizecod,
                                              input logic [1:0] fscod);
    logic [9:0]  kbps;
    logic [10:0] w;
    kbps = bitrate(frmsizecod);
    case (fscod)
      2'd0:    w = {kbps, 1'b0};
      2'd1:    w = words_44k(frmsizecod);
      2'd2:    w = {kbps, 1'b0} + {1'b0, kbps};
      default: w = 11'd0;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/ac3sh_parse.sv
// ----------------------------------------------------------------------------
// ac3sh_parse
// Per-byte sync search and header capture; one result per buffer.
// ----------------------------------------------------------------------------
module ac3sh_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  ac3sh_pkg::byte_req_t req,
  output logic                res_valid,
  output ac3sh_pkg::result_t  res
);

  logic [15:0]       sync_window, sync_window_next;
  logic [15:0]       byte_position, byte_position_next;
  ac3sh_pkg::phase_t phase, phase_next;
  logic [1:0]        header_index, header_index_next;
  logic [7:0]        code_byte, code_byte_next;

  logic [15:0] window_shift;
  logic [15:0] offset;
  logic [15:0] pos_inc_sat;
  logic        sync_hit, bound_hit, hdr_done, trunc;
  logic [1:0]  fscod;
  logic [5:0]  frmsizecod;

  assign window_shift = {sync_window[7:0], req.data_byte};
  assign offset       = byte_position - 16'd1;
  assign pos_inc_sat  = (byte_position == ac3sh_pkg::POS_MAX) ? ac3sh_pkg::POS_MAX
                                                              : byte_position + 16'd1;
  assign fscod        = code_byte[7:6];
  assign frmsizecod   = code_byte[5:0];

  assign sync_hit  = (phase == ac3sh_pkg::PH_SEARCH) && (byte_position != 16'd0) &&
                     (window_shift == ac3sh_pkg::SYNC_WORD);
  assign bound_hit = (phase == ac3sh_pkg::PH_SEARCH) && (byte_position != 16'd0) &&
                     (window_shift != ac3sh_pkg::SYNC_WORD) &&
                     (({1'b0, offset} + ac3sh_pkg::SEARCH_TAIL) >= {1'b0, req.buffer_length});
  assign hdr_done  = (phase == ac3sh_pkg::PH_HEADER) && (header_index == ac3sh_pkg::HDR_BSID);
  // last mark arriving before any result for this buffer
  assign trunc     = req.last_byte && !bound_hit && !hdr_done &&
                     (phase != ac3sh_pkg::PH_DRAIN);

  // next state
  always_comb begin
    sync_window_next   = sync_window;
    byte_position_next = byte_position;
    phase_next         = phase;
    header_index_next  = header_index;
    code_byte_next     = code_byte;
    if (req_valid) begin
      case (phase)
        ac3sh_pkg::PH_SEARCH: begin
          sync_window_next = window_shift;
          if (sync_hit) begin
            phase_next        = ac3sh_pkg::PH_HEADER;
            header_index_next = 2'd0;
          end else if (bound_hit) begin
            phase_next = ac3sh_pkg::PH_DRAIN;
          end
        end
        ac3sh_pkg::PH_HEADER: begin
          if (header_index == ac3sh_pkg::HDR_CODE) begin
            code_byte_next = req.data_byte;
          end
          if (hdr_done) begin
            phase_next = ac3sh_pkg::PH_DRAIN;
          end else begin
            header_index_next = header_index + 2'd1;
          end
        end
        default: begin
        end
      endcase
      if (req.last_byte) begin
        sync_window_next   = '0;
        byte_position_next = '0;
        phase_next         = ac3sh_pkg::PH_SEARCH;
        header_index_next  = '0;
        code_byte_next     = '0;
      end else begin
        byte_position_next = pos_inc_sat;
      end
    end
  end

  // result
  always_comb begin
    res       = '0;
    res_valid = req_valid && (bound_hit || hdr_done || trunc);
    if (trunc) begin
      res.status        = ac3sh_pkg::ST_NO_SYNC;
      res.skipped_bytes = pos_inc_sat;
    end else if (bound_hit) begin
      res.status        = ac3sh_pkg::ST_NO_SYNC;
      res.skipped_bytes = offset;
    end else if (hdr_done) begin
      res.skipped_bytes = (byte_position >= ac3sh_pkg::HEADER_LEAD) ?
                          byte_position - ac3sh_pkg::HEADER_LEAD : 16'd0;
      if (fscod == ac3sh_pkg::FSCOD_RESERVED) begin
        res.status = ac3sh_pkg::ST_BAD_RATE;
      end else begin
        res.sample_rate_hz = ac3sh_pkg::sample_rate(fscod);
        if (frmsizecod < ac3sh_pkg::FRMSIZE_CODES) begin
          res.frame_bytes  = {ac3sh_pkg::frame_words(frmsizecod, fscod), 1'b0};
          res.bitrate_kbps = ac3sh_pkg::bitrate(frmsizecod);
        end
        if (req.data_byte[7:3] != ac3sh_pkg::BSID_EXPECTED) begin
          res.status = ac3sh_pkg::ST_BAD_BSID;
        end else begin
          res.status      = ac3sh_pkg::ST_OK;
          res.stream_mode = req.data_byte[2:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_window   <= '0;
      byte_position <= '0;
      phase         <= ac3sh_pkg::PH_SEARCH;
      header_index  <= '0;
      code_byte     <= '0;
    end else begin
      sync_window   <= sync_window_next;
      byte_position <= byte_position_next;
      phase         <= phase_next;
      header_index  <= header_index_next;
      code_byte     <= code_byte_next;
    end
  end

endmodule

FILE: rtl/core/ac3sh_result_buf.sv
// ----------------------------------------------------------------------------
// ac3sh_result_buf
// Result output register with one skid entry behind it.
// ----------------------------------------------------------------------------
module ac3sh_result_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ac3sh_pkg::result_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output ac3sh_pkg::result_t out_data
);

  ac3sh_pkg::result_t skid_data;
  logic               skid_valid;
  logic               pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (out_valid && !pop) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (out_valid && !pop) begin
      if (push) begin
        skid_data <= push_data;
      end
    end else if (push) begin
      out_data <= push_data;
    end
  end

endmodule

FILE: rtl/core/ac3_sync_header_parser_core.sv
// ----------------------------------------------------------------------------
// ac3_sync_header_parser_core
// AC-3 syncinfo/BSI header parser: finds 0x0B77 and reports frame parameters.
// ----------------------------------------------------------------------------
// Takes one byte per clock and emits one result request per buffer. Each byte
// is registered on acceptance; the sync search / header step runs on it while
// the skid entry is free, and any result lands in the output register or its
// skid entry, so a result is registered after the byte that completes it (the
// byte that reaches the search bound, the bsid byte, or the last byte of a
// short buffer). Sustained rate is one byte per cycle; byte_stall rises only
// when the output register and its skid entry both hold results that have
// not been taken. No clearing pass after reset.
module ac3_sync_header_parser_core (
  input  logic        clk,
  input  logic        rst,
  // byte channel
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic [15:0] buffer_length,
  input  logic        last_byte,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  status,
  output logic [15:0] skipped_bytes,
  output logic [15:0] sample_rate_hz,
  output logic [11:0] frame_bytes,
  output logic [9:0]  bitrate_kbps,
  output logic [2:0]  stream_mode
);

  // Input register: one byte request waiting for the parse step.
  ac3sh_pkg::byte_req_t byte_req;
  logic                 byte_req_valid;
  logic                 byte_accept;
  logic                 step;      // parse step consumes byte_req this cycle

  // Parse step to result buffer.
  logic                 res_valid;
  ac3sh_pkg::result_t   res;
  logic                 buf_full;
  ac3sh_pkg::result_t   out_data;

  // The step only holds off while the skid entry is occupied, so the held
  // byte always has a place for the result it may produce.
  assign step        = byte_req_valid && !buf_full;
  assign byte_stall  = byte_req_valid && buf_full;
  assign byte_accept = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_req_valid <= 1'b0;
    end else if (byte_accept) begin
      byte_req_valid <= 1'b1;
    end else if (step) begin
      byte_req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_accept) begin
      byte_req.data_byte     <= data_byte;
      byte_req.buffer_length <= buffer_length;
      byte_req.last_byte     <= last_byte;
    end
  end

  ac3sh_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .req_valid (step),
    .req       (byte_req),
    .res_valid (res_valid),
    .res       (res)
  );

  ac3sh_result_buf u_result_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_data  (out_data)
  );

  assign status         = out_data.status;
  assign skipped_bytes  = out_data.skipped_bytes;
  assign sample_rate_hz = out_data.sample_rate_hz;
  assign frame_bytes    = out_data.frame_bytes;
  assign bitrate_kbps   = out_data.bitrate_kbps;
  assign stream_mode    = out_data.stream_mode;

endmodule

FILE: rtl/core/ac3sh_checker.sv
// ----------------------------------------------------------------------------
// ac3sh_checker
// Port-level checks for the AC-3 sync/header parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ac3sh_checker (
  input logic        clk,
  input logic        rst,
  input logic        byte_valid,
  input logic        byte_stall,
  input logic [7:0]  data_byte,
  input logic [15:0] buffer_length,
  input logic        last_byte,
  input logic        result_valid,
  input logic        result_stall,
  input logic [1:0]  status,
  input logic [15:0] skipped_bytes,
  input logic [15:0] sample_rate_hz,
  input logic [11:0] frame_bytes,
  input logic [9:0]  bitrate_kbps,
  input logic [2:0]  stream_mode
);

  logic no_sync, bad_rate, ok;

  assign no_sync  = result_valid && (status == ac3sh_pkg::ST_NO_SYNC);
  assign bad_rate = result_valid && (status == ac3sh_pkg::ST_BAD_RATE);
  assign ok       = result_valid && (status == ac3sh_pkg::ST_OK);

  `ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(status) && $stable(skipped_bytes) && $stable(frame_bytes), "stalled result changed")
  `ASSERT_SAME(a_stall_needs_result, byte_stall, result_valid, "byte stall with no result pending")
  `ASSERT_SAME(a_no_sync_fields, no_sync, sample_rate_hz == 16'd0 && frame_bytes == 12'd0 && bitrate_kbps == 10'd0 && stream_mode == 3'd0, "no-sync result carries header fields")
  `ASSERT_SAME(a_bad_rate_fields, bad_rate, sample_rate_hz == 16'd0 && frame_bytes == 12'd0 && bitrate_kbps == 10'd0, "reserved rate result carries rate fields")
  `ASSERT_SAME(a_ok_rate, ok, sample_rate_hz == 16'd48000 || sample_rate_hz == 16'd44100 || sample_rate_hz == 16'd32000, "ok result with bad sample rate")

endmodule

bind ac3_sync_header_parser_core ac3sh_checker u_ac3sh_checker (.*);
